// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the checker module
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is high
`define BVC_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("bvc assertion failed");

// clocked assertion that also holds across reset
`define BVC_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("bvc assertion failed");

`endif

// ===== rtl/core/bvc_pkg.sv =====
// types, codes and reset values for the battery voltage conditioner
// no dependencies
`default_nettype none

package bvc_pkg;

  localparam int TIME_W  = 32;
  localparam int MV_W    = 15;
  localparam int VOLT_W  = 16;
  localparam int COEF_W  = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOINIT  = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;
  localparam logic [1:0] ST_HWERR   = 2'd3;

  // charging state codes
  localparam logic [1:0] CHG_UNKNOWN = 2'd0;
  localparam logic [1:0] CHG_ON      = 2'd1;
  localparam logic [1:0] CHG_OFF     = 2'd2;

  // power source codes
  localparam logic [1:0] SRC_UNKNOWN  = 2'd0;
  localparam logic [1:0] SRC_EXTERNAL = 2'd1;
  localparam logic [1:0] SRC_BATTERY  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLED      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_COEF  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHG_THRESH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NOBAT_THRESH = 3'd4;

  // configuration reset values
  localparam logic [TIME_W-1:0] RST_MIN_INTERVAL = 32'd1000;
  localparam logic [COEF_W-1:0] RST_FILTER_COEF  = 16'd6554;
  localparam logic [MV_W-1:0]   RST_CHG_THRESH   = 15'd4190;
  localparam logic [MV_W-1:0]   RST_NOBAT_THRESH = 15'd2000;

  localparam logic [VOLT_W-1:0] VOLT_NONE = 16'hFFFF;

  typedef struct packed {
    logic              enabled;
    logic [TIME_W-1:0] min_interval_ms;
    logic [COEF_W-1:0] filter_coef;
    logic [MV_W-1:0]   charging_threshold_mv;
    logic [MV_W-1:0]   no_battery_threshold_mv;
  } cfg_t;

  typedef struct packed {
    logic [VOLT_W-1:0] volt_mv;
    logic              present;
    logic [1:0]        charging_state;
    logic [1:0]        power_source;
    logic              reading_valid;
  } reading_t;

endpackage

`default_nettype wire

// ===== rtl/core/bvc_if.sv =====
// request and result channel interfaces of the battery voltage conditioner
// depends on bvc_pkg
`default_nettype none

interface bvc_req_if import bvc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] time_ms;
  logic [MV_W-1:0]   raw_mv;
  logic              raw_ok;

  modport source(output valid, time_ms, raw_mv, raw_ok, input ready);
  modport sink(input valid, time_ms, raw_mv, raw_ok, output ready);
endinterface

interface bvc_rsp_if import bvc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [VOLT_W-1:0] volt_mv;
  logic              present;
  logic [1:0]        charging_state;
  logic [1:0]        power_source;
  logic              reading_valid;

  modport source(output valid, status, volt_mv, present, charging_state,
                 power_source, reading_valid, input ready);
  modport sink(input valid, status, volt_mv, present, charging_state,
               power_source, reading_valid, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/battery_voltage_conditioner.sv =====
// battery voltage conditioner: request register, filter state, result register
// depends on bvc_pkg, bvc_if, bvc_cfg, bvc_ema
//
// Requests arrive on req (time_ms, raw_mv, raw_ok) and each one gives exactly
// one result on rsp (status, volt_mv, present, charging_state,
// power_source, reading_valid), in order, with valid/ready handshakes on both.
// A request is registered on acceptance and evaluated against the filter and
// cache state as it advances to the result register, which holds the answer.
// Throughput is one request per cycle while rsp is not stalled: the state
// update for one request lands in the same cycle as its result, so the
// following request sees it at once. The multiply of coefficient by sample
// delta and the following add set the critical path. When rsp is stalled the
// result holds, the request register fills, and req ready drops only once both
// are occupied. The user must write configuration through
// cfg_we/cfg_index/cfg_data while idle; the block does not enforce it. Reset
// (synchronous, active high) empties both registers, clears the filter and
// cache and restores the configuration defaults.
`default_nettype none

module battery_voltage_conditioner import bvc_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  bvc_req_if.sink                    req,
  bvc_rsp_if.source                  rsp,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg;

  // request register
  logic              req_full;
  logic [TIME_W-1:0] req_time;
  logic [MV_W-1:0]   req_raw;
  logic              req_ok;

  // filter and cache state
  logic [MV_W-1:0]   avg_mv;
  logic              filter_seeded;
  logic [TIME_W-1:0] last_read_ms;
  reading_t          cache;

  // result register
  logic              rsp_full;
  logic [1:0]        rsp_status;
  reading_t          rsp_reading;

  logic              advance;
  logic              fresh;
  logic              take_sample;
  logic [TIME_W-1:0] elapsed;
  logic [MV_W-1:0]   filtered_next;
  reading_t          sample_reading;
  logic [1:0]        status_next;
  reading_t          reading_next;

  bvc_cfg u_cfg (
    .clk   (clk),
    .rst   (rst),
    .we    (cfg_we),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  bvc_ema u_ema (
    .avg_mv                  (avg_mv),
    .seeded                  (filter_seeded),
    .raw_mv                  (req_raw),
    .coef                    (cfg.filter_coef),
    .charging_threshold_mv   (cfg.charging_threshold_mv),
    .no_battery_threshold_mv (cfg.no_battery_threshold_mv),
    .filtered_next           (filtered_next),
    .reading                 (sample_reading)
  );

  assign advance   = req_full && (!rsp_full || rsp.ready);
  assign req.ready = !req_full || advance;

  assign elapsed = req_time - last_read_ms;
  // zero read time means never read
  assign fresh   = (last_read_ms == '0) || (elapsed >= cfg.min_interval_ms);
  assign take_sample = cfg.enabled && fresh && req_ok;

  always_comb begin
    status_next  = ST_OK;
    reading_next = cache;
    if (!cfg.enabled) begin
      status_next                  = ST_NOINIT;
      reading_next.volt_mv         = VOLT_NONE;
      reading_next.present         = 1'b0;
      reading_next.charging_state  = CHG_UNKNOWN;
      reading_next.power_source    = SRC_UNKNOWN;
      reading_next.reading_valid   = 1'b0;
    end else if (!fresh) begin
      status_next = cache.reading_valid ? ST_OK : ST_INVALID;
    end else if (!req_ok) begin
      status_next = ST_HWERR;
    end else begin
      reading_next = sample_reading;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_full <= 1'b0;
    end else if (req.valid && req.ready) begin
      req_full <= 1'b1;
    end else if (advance) begin
      req_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      req_time <= req.time_ms;
      req_raw  <= req.raw_mv;
      req_ok   <= req.raw_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      avg_mv                <= '0;
      filter_seeded         <= 1'b0;
      last_read_ms          <= '0;
      cache.volt_mv         <= VOLT_NONE;
      cache.present         <= 1'b0;
      cache.charging_state  <= CHG_UNKNOWN;
      cache.power_source    <= SRC_UNKNOWN;
      cache.reading_valid   <= 1'b0;
    end else if (advance && take_sample) begin
      avg_mv        <= filtered_next;
      filter_seeded <= 1'b1;
      last_read_ms  <= req_time;
      cache         <= sample_reading;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_full <= 1'b0;
    end else if (advance) begin
      rsp_full <= 1'b1;
    end else if (rsp.ready) begin
      rsp_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp_status  <= status_next;
      rsp_reading <= reading_next;
    end
  end

  assign rsp.valid           = rsp_full;
  assign rsp.status          = rsp_status;
  assign rsp.volt_mv         = rsp_reading.volt_mv;
  assign rsp.present         = rsp_reading.present;
  assign rsp.charging_state  = rsp_reading.charging_state;
  assign rsp.power_source    = rsp_reading.power_source;
  assign rsp.reading_valid   = rsp_reading.reading_valid;

endmodule

`default_nettype wire

// ===== rtl/core/bvc_cfg.sv =====
// configuration register bank of the battery voltage conditioner
// depends on bvc_pkg
`default_nettype none

module bvc_cfg import bvc_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  we,
  input  wire logic [CFG_IDX_W-1:0]  index,
  input  wire logic [CFG_DATA_W-1:0] data,
  output cfg_t                       cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enabled                 <= 1'b0;
      cfg.min_interval_ms         <= RST_MIN_INTERVAL;
      cfg.filter_coef             <= RST_FILTER_COEF;
      cfg.charging_threshold_mv   <= RST_CHG_THRESH;
      cfg.no_battery_threshold_mv <= RST_NOBAT_THRESH;
    end else if (we) begin
      case (index)
        CFG_ENABLED:      cfg.enabled                 <= data[0];
        CFG_MIN_INTERVAL: cfg.min_interval_ms         <= data[TIME_W-1:0];
        CFG_FILTER_COEF:  cfg.filter_coef             <= data[COEF_W-1:0];
        CFG_CHG_THRESH:   cfg.charging_threshold_mv   <= data[MV_W-1:0];
        CFG_NOBAT_THRESH: cfg.no_battery_threshold_mv <= data[MV_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/bvc_ema.sv =====
// moving average update and threshold classification for one sample
// depends on bvc_pkg
`default_nettype none

module bvc_ema import bvc_pkg::*; (
  input  wire logic [MV_W-1:0]   avg_mv,
  input  wire logic              seeded,
  input  wire logic [MV_W-1:0]   raw_mv,
  input  wire logic [COEF_W-1:0] coef,
  input  wire logic [MV_W-1:0]   charging_threshold_mv,
  input  wire logic [MV_W-1:0]   no_battery_threshold_mv,
  output logic [MV_W-1:0]        filtered_next,
  output reading_t               reading
);

  logic signed [VOLT_W-1:0] delta;
  logic signed [32:0]       prod;
  logic signed [32:0]       step;
  logic signed [32:0]       sum;
  logic                     charging_v;

  assign delta = $signed({1'b0, raw_mv}) - $signed({1'b0, avg_mv});
  assign prod  = $signed({1'b0, coef}) * delta;
  // arithmetic shift floors negative products
  assign step  = prod >>> COEF_W;
  assign sum   = $signed({18'd0, avg_mv}) + step;

  assign filtered_next = seeded ? sum[MV_W-1:0] : raw_mv;

  assign charging_v = filtered_next >= charging_threshold_mv;

  always_comb begin
    reading.volt_mv = {1'b0, filtered_next};
    reading.present = filtered_next >= no_battery_threshold_mv;
    if (filtered_next == '0) begin
      reading.charging_state = CHG_UNKNOWN;
    end else begin
      reading.charging_state = charging_v ? CHG_ON : CHG_OFF;
    end
    reading.power_source  = charging_v ? SRC_EXTERNAL : SRC_BATTERY;
    reading.reading_valid = 1'b1;
  end

endmodule

`default_nettype wire

// ===== rtl/core/bvc_checker.sv =====
// port-level checks for the battery voltage conditioner, bound to the top level
// depends on bvc_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module bvc_checker import bvc_pkg::*; (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              req_valid,
  input wire logic              req_ready,
  input wire logic              rsp_valid,
  input wire logic              rsp_ready,
  input wire logic [1:0]        status,
  input wire logic [VOLT_W-1:0] volt_mv,
  input wire logic              reading_valid
);

  // nothing comes out right after reset
  `BVC_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !rsp_valid)

  // a stalled result holds
  `BVC_ASSERT(a_stall_hold, clk, rst,
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(volt_mv))

  // an accepted request is later followed by a valid result
  `BVC_ASSERT(a_latency, clk, rst, req_valid && req_ready |-> ##2 rsp_valid)

  // success always carries a filled cache
  `BVC_ASSERT(a_ok_valid, clk, rst,
    rsp_valid && status == ST_OK |-> reading_valid && volt_mv != VOLT_NONE)

endmodule

bind battery_voltage_conditioner bvc_checker u_bvc_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .status        (rsp.status),
  .volt_mv       (rsp.volt_mv),
  .reading_valid (rsp.reading_valid)
);

`default_nettype wire

// ===== test/testbench.sv =====
// self-checking testbench for battery_voltage_conditioner: a queue-fed request driver,
// a result monitor and a filter and cache predictor checked in order
// depends on bvc_pkg, bvc_if and the rtl of the block
`timescale 1ns / 100ps

module testbench;
  import bvc_pkg::*;

  typedef struct packed {
    logic [TIME_W-1:0] time_ms;
    logic [MV_W-1:0]   raw_mv;
    logic              raw_ok;
  } sample_req_t;

  typedef struct packed {
    logic [1:0] status;
    reading_t   rd;
  } reading_rsp_t;

  localparam int WATCHDOG_CYCLES = 2000;
  localparam int PHASE_ITEMS     = 250;
  localparam int RANDOM_PHASES   = 8;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  req_valid  = 1'b0;
  sample_req_t           req_drive  = '0;
  logic                  rsp_ready  = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  bvc_req_if req_ch ();
  bvc_rsp_if rsp_ch ();

  assign req_ch.valid   = req_valid;
  assign req_ch.time_ms = req_drive.time_ms;
  assign req_ch.raw_mv  = req_drive.raw_mv;
  assign req_ch.raw_ok  = req_drive.raw_ok;
  assign rsp_ch.ready   = rsp_ready;

  battery_voltage_conditioner dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // shadow of the block: configuration, filter and cached reading
  cfg_t              shadow_cfg;
  logic [MV_W-1:0]   avg_mv;
  logic              avg_seeded;
  logic [TIME_W-1:0] last_sample_ms;
  reading_t          held_reading;

  sample_req_t  pending_reqs[$];
  reading_rsp_t expected_readings[$];
  sample_req_t  cur_req = '0;

  int mismatch_count = 0;
  int send_gap = 0;
  int stall_left = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  bit quiet_tail = 1'b0;
  int quiet_cycles = 0;
  logic [TIME_W-1:0] clock_ms = '0;

  function automatic reading_rsp_t predict_reading(sample_req_t it);
    reading_rsp_t r;
    logic [MV_W-1:0] v;
    logic chg_hi;
    longint coef;
    longint diff;
    longint next_avg;
    r.status = ST_OK;
    r.rd = held_reading;
    if (!shadow_cfg.enabled) begin
      r.status = ST_NOINIT;
      r.rd.volt_mv = VOLT_NONE;
      r.rd.present = 1'b0;
      r.rd.charging_state = CHG_UNKNOWN;
      r.rd.power_source = SRC_UNKNOWN;
      r.rd.reading_valid = 1'b0;
    end else if (last_sample_ms != 0 &&
                 TIME_W'(it.time_ms - last_sample_ms) < shadow_cfg.min_interval_ms) begin
      r.status = held_reading.reading_valid ? ST_OK : ST_INVALID;
    end else if (!it.raw_ok) begin
      r.status = ST_HWERR;
    end else begin
      if (!avg_seeded) begin
        v = it.raw_mv;
      end else begin
        coef = longint'(shadow_cfg.filter_coef);
        diff = longint'(it.raw_mv) - longint'(avg_mv);
        // arithmetic shift floors negative products too
        next_avg = longint'(avg_mv) + ((coef * diff) >>> 16);
        v = next_avg[MV_W-1:0];
      end
      avg_mv = v;
      avg_seeded = 1'b1;
      chg_hi = (v >= shadow_cfg.charging_threshold_mv);
      held_reading.volt_mv = {1'b0, v};
      held_reading.present = (v >= shadow_cfg.no_battery_threshold_mv);
      if (v == 0) held_reading.charging_state = CHG_UNKNOWN;
      else held_reading.charging_state = chg_hi ? CHG_ON : CHG_OFF;
      held_reading.power_source = chg_hi ? SRC_EXTERNAL : SRC_BATTERY;
      held_reading.reading_valid = 1'b1;
      last_sample_ms = it.time_ms;
      r.rd = held_reading;
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("mismatch on %s at %0t: expected %0h, got %0h", name, $time, want, got);
    end
  endtask

  // request driver
  always @(posedge clk) begin : driver
    if (rst) begin
      req_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (req_valid && req_ch.ready)
        expected_readings.push_back(predict_reading(cur_req));
      if (!req_valid || req_ch.ready) begin
        if (send_gap != 0) begin
          send_gap--;
          req_valid <= 1'b0;
        end else if (pending_reqs.size() != 0 && !quiet_tail &&
                     $urandom_range(0, 99) < send_idle_pct) begin
          send_gap = $urandom_range(0, 15);
          req_valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          cur_req = pending_reqs.pop_front();
          req_drive <= cur_req;
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : monitor
    reading_rsp_t want;
    if (rst) begin
      rsp_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (rsp_ch.valid && rsp_ready) begin
        if (expected_readings.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result transaction at %0t", $time);
        end else begin
          want = expected_readings.pop_front();
          check_field("status", 16'(want.status), 16'(rsp_ch.status));
          check_field("volt_mv", want.rd.volt_mv, rsp_ch.volt_mv);
          check_field("present", 16'(want.rd.present), 16'(rsp_ch.present));
          check_field("charging_state", 16'(want.rd.charging_state),
                      16'(rsp_ch.charging_state));
          check_field("power_source", 16'(want.rd.power_source),
                      16'(rsp_ch.power_source));
          check_field("reading_valid", 16'(want.rd.reading_valid),
                      16'(rsp_ch.reading_valid));
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        rsp_ready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(0, 15);
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((req_valid && req_ch.ready) || (rsp_ch.valid && rsp_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("timeout: no transaction for %0d cycles", WATCHDOG_CYCLES);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_req(input logic [TIME_W-1:0] t, input logic [MV_W-1:0] mv,
                          input logic ok);
    sample_req_t it;
    it.time_ms = t;
    it.raw_mv = mv;
    it.raw_ok = ok;
    pending_reqs.push_back(it);
  endtask

  task automatic drain();
    while (pending_reqs.size() != 0 || req_valid || expected_readings.size() != 0)
      @(posedge clk);
  endtask

  // writes every register, block must be idle
  task automatic apply_config(input cfg_t c);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_ENABLED;
    cfg_data <= CFG_DATA_W'(c.enabled);
    @(posedge clk);
    cfg_index <= CFG_MIN_INTERVAL;
    cfg_data <= CFG_DATA_W'(c.min_interval_ms);
    @(posedge clk);
    cfg_index <= CFG_FILTER_COEF;
    cfg_data <= CFG_DATA_W'(c.filter_coef);
    @(posedge clk);
    cfg_index <= CFG_CHG_THRESH;
    cfg_data <= CFG_DATA_W'(c.charging_threshold_mv);
    @(posedge clk);
    cfg_index <= CFG_NOBAT_THRESH;
    cfg_data <= CFG_DATA_W'(c.no_battery_threshold_mv);
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_cfg = c;
  endtask

  function automatic logic [MV_W-1:0] pick_mv(input logic [MV_W-1:0] a,
                                              input logic [MV_W-1:0] b);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return MV_W'(a + $urandom_range(0, 6) - 3);
      3: return MV_W'(b + $urandom_range(0, 6) - 3);
      default: return MV_W'($urandom_range(0, 32767));
    endcase
  endfunction

  initial begin : stimulus
    cfg_t c;
    shadow_cfg.enabled = 1'b0;
    shadow_cfg.min_interval_ms = RST_MIN_INTERVAL;
    shadow_cfg.filter_coef = RST_FILTER_COEF;
    shadow_cfg.charging_threshold_mv = RST_CHG_THRESH;
    shadow_cfg.no_battery_threshold_mv = RST_NOBAT_THRESH;
    avg_mv = '0;
    avg_seeded = 1'b0;
    last_sample_ms = '0;
    held_reading.volt_mv = VOLT_NONE;
    held_reading.present = 1'b0;
    held_reading.charging_state = CHG_UNKNOWN;
    held_reading.power_source = SRC_UNKNOWN;
    held_reading.reading_valid = 1'b0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // disabled after reset
    push_req(32'hFFFF_FFFF, 15'h7FFF, 1'b1);
    push_req(32'h0, 15'h0, 1'b0);
    drain();

    // default settings, enabled: seed, early reads, hardware errors, time zero, wrap
    c = '{1'b1, 32'd1000, 16'd6554, 15'd4190, 15'd2000};
    apply_config(c);
    push_req(32'd500, 15'd1234, 1'b0);
    push_req(32'd600, 15'd4200, 1'b1);
    push_req(32'd700, 15'd100, 1'b1);
    push_req(32'd1600, 15'd0, 1'b1);
    push_req(32'd2600, 15'd32767, 1'b1);
    push_req(32'd3700, 15'd5, 1'b0);
    push_req(32'd0, 15'd3000, 1'b1);
    push_req(32'd5, 15'd1500, 1'b1);
    push_req(32'd6, 15'd1500, 1'b1);
    push_req(32'hFFFF_FF00, 15'd2500, 1'b1);
    push_req(32'h0000_0100, 15'd2500, 1'b1);
    push_req(32'h0000_02F0, 15'd2600, 1'b1);
    drain();

    // full coefficient drives the average to zero, thresholds at zero
    c = '{1'b1, 32'd0, 16'hFFFF, 15'd0, 15'd0};
    apply_config(c);
    push_req(32'd10, 15'd0, 1'b1);
    push_req(32'd10, 15'd32767, 1'b1);
    push_req(32'd11, 15'd0, 1'b1);
    drain();

    // largest interval, zero coefficient, top thresholds
    c = '{1'b1, 32'hFFFF_FFFF, 16'd0, 15'h7FFF, 15'h7FFF};
    apply_config(c);
    push_req(32'd10, 15'd7, 1'b1);
    push_req(32'd20, 15'd7, 1'b1);
    push_req(32'd9, 15'd7, 1'b1);
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      c.enabled = ($urandom_range(0, 7) != 0);
      case ($urandom_range(0, 5))
        0: c.min_interval_ms = 32'd0;
        1: c.min_interval_ms = 32'd1;
        2: c.min_interval_ms = RST_MIN_INTERVAL;
        3: c.min_interval_ms = $urandom_range(2, 3000);
        4: c.min_interval_ms = $urandom;
        default: c.min_interval_ms = 32'hFFFF_FFFF;
      endcase
      case ($urandom_range(0, 4))
        0: c.filter_coef = 16'd0;
        1: c.filter_coef = 16'hFFFF;
        2: c.filter_coef = 16'd1;
        default: c.filter_coef = COEF_W'($urandom_range(0, 65535));
      endcase
      c.charging_threshold_mv = ($urandom_range(0, 5) == 0) ? 15'h7FFF :
                                MV_W'($urandom_range(0, 32767));
      c.no_battery_threshold_mv = ($urandom_range(0, 5) == 0) ? 15'h0 :
                                  MV_W'($urandom_range(0, 32767));
      apply_config(c);
      quiet_tail = (p == RANDOM_PHASES - 1);
      case ($urandom_range(0, 3))
        0: send_idle_pct = 0;
        1: send_idle_pct = 5;
        2: send_idle_pct = 15;
        default: send_idle_pct = 30;
      endcase
      stall_pct = (p % 3 == 0) ? 0 : $urandom_range(5, 30);
      if ($urandom_range(0, 2) == 0) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 5000);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        case ($urandom_range(0, 19))
          0: clock_ms = $urandom;
          1: clock_ms = '0;
          2, 3, 4: clock_ms = clock_ms + shadow_cfg.min_interval_ms - 1;
          5, 6, 7, 8, 9, 10, 11, 12:
            clock_ms = clock_ms + shadow_cfg.min_interval_ms + $urandom_range(0, 40);
          default: clock_ms = clock_ms + $urandom_range(0, 2000);
        endcase
        push_req(clock_ms,
                 pick_mv(shadow_cfg.charging_threshold_mv,
                         shadow_cfg.no_battery_threshold_mv),
                 ($urandom_range(0, 99) < 85));
      end
      drain();
    end

    repeat (6) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/bvc_pkg.sv
rtl/core/bvc_if.sv
rtl/core/bvc_cfg.sv
rtl/core/bvc_ema.sv
rtl/core/battery_voltage_conditioner.sv
rtl/core/bvc_checker.sv
test/testbench.sv
